>>> rtl/core/rtfp_pkg.sv
// Shared types and constants for the RTF token event parser.
// Holds keyword tables, lexer mode codes, event codes and the per-item work record.
// No dependencies.
`default_nettype none

package rtfp_pkg;

	// skip counter
	localparam int unsigned MAX_SKIP_DEPTH = 255;
	localparam int unsigned SKW = $clog2(MAX_SKIP_DEPTH + 1);

	// lexer modes
	localparam logic [2:0] M_TEXT  = 3'd0;
	localparam logic [2:0] M_ESC   = 3'd1;
	localparam logic [2:0] M_WORD  = 3'd2;
	localparam logic [2:0] M_MINUS = 3'd3;
	localparam logic [2:0] M_NUM   = 3'd4;

	// brace escape tracking
	localparam logic [1:0] BE_NONE  = 2'd0;
	localparam logic [1:0] BE_BRACE = 2'd1;
	localparam logic [1:0] BE_SLASH = 2'd2;

	// event kinds
	localparam logic [1:0] EV_TEXT = 2'd0;
	localparam logic [1:0] EV_PAR  = 2'd1;
	localparam logic [1:0] EV_CELL = 2'd2;
	localparam logic [1:0] EV_ROW  = 2'd3;

	// input kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// keyword indexes
	localparam logic [2:0] KW_PAR   = 3'd0;
	localparam logic [2:0] KW_PARD  = 3'd1;
	localparam logic [2:0] KW_B     = 3'd2;
	localparam logic [2:0] KW_TROWD = 3'd3;
	localparam logic [2:0] KW_CELL  = 3'd4;
	localparam logic [2:0] KW_ROW   = 3'd5;
	localparam logic [2:0] KW_LINE  = 3'd6;
	localparam logic [2:0] KW_TAB   = 3'd7;

	// keyword spelling, padded with zeros to eight characters
	localparam logic [7:0] KW_TEXT [8][8] = '{
		'{"p", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"p", "a", "r", "d", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"b", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "r", "o", "w", "d", 8'h00, 8'h00, 8'h00},
		'{"c", "e", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"r", "o", "w", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"l", "i", "n", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "a", "b", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};
	localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd4, 3'd1, 3'd5, 3'd4, 3'd3, 3'd4, 3'd3};

	// special characters
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// parser state
	typedef struct packed {
		logic           started;
		logic [2:0]     mode;
		logic [1:0]     besc;
		logic [SKW-1:0] skip;
		logic [7:0]     wmatch;
		logic [2:0]     wlen;
		logic           pseen;
		logic           pnz;
		logic           bold;
		logic           table_on;
		logic           tpend;
		logic           rowc;
	} st_t;

	// one event
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] text;
		logic       bold;
	} ev_t;

	// state plus the events one item causes
	typedef struct packed {
		st_t           s;
		ev_t [2:0]     ev;
		logic [1:0]    n;
	} work_t;

	localparam st_t ST_RESET = '{
		started: 1'b0, mode: M_TEXT, besc: BE_NONE, skip: '0, wmatch: 8'h00,
		wlen: 3'd0, pseen: 1'b0, pnz: 1'b0, bold: 1'b0, table_on: 1'b0,
		tpend: 1'b0, rowc: 1'b0
	};

endpackage

`default_nettype wire

>>> rtl/core/rtf_token_event_parser.sv
// RTF token event parser top level: lexer, control word matcher and event buffer.
// Depends on rtfp_pkg.
//
//   channel  dir  tdata                               tuser        tlast
//   s_*      in   [7:0] byte_value                    kind         -
//   m_*      out  [7:0] text_byte, [8] bold_flag      event_kind   last_of_run
//
// Each request is parsed in the cycle it is accepted; its zero to three events are
// loaded into a three-entry result buffer that drains one event per cycle while
// m_tready is high. Requests yielding one event or none stream back to back while
// the receiver is ready; one yielding more holds the input while the buffer drains.
// arst_n clears the parser state and empties the buffer; an end-of-input request
// flushes and then returns the parser to its reset state.
`default_nettype none

module rtf_token_event_parser (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] byte_value
	input  wire logic       s_tuser,   // [0] kind
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [15:0]     m_tdata,   // [7:0] text_byte, [8] bold_flag, [15:9] zero
	output logic [1:0]      m_tuser,   // [1:0] event_kind
	output logic            m_tlast    // last_of_run
);
	import rtfp_pkg::*;

	st_t        st_q;
	ev_t        buf_q [3];
	logic [1:0] cnt_q;
	work_t      w_nxt;
	logic       s_acc;
	logic       m_acc;

	// ---------------------------------------------------------------------
	// event helpers
	function automatic work_t f_emit(work_t w, logic [1:0] k, logic [7:0] t, logic b);
		work_t r;
		r = w;
		if (r.n != 2'd3) begin
			r.ev[r.n] = '{kind: k, text: t, bold: b};
			r.n = r.n + 2'd1;
		end
		return r;
	endfunction

	function automatic work_t f_append(work_t w, logic [7:0] c);
		work_t r;
		r = f_emit(w, EV_TEXT, c, 1'b0);
		r.s.tpend = 1'b1;
		return r;
	endfunction

	function automatic work_t f_para_end(work_t w);
		work_t r;
		r = w;
		if (r.s.tpend) begin
			r = f_emit(r, EV_PAR, 8'h00, r.s.bold);
			r.s.tpend = 1'b0;
			r.s.bold  = 1'b0;
		end
		return r;
	endfunction

	function automatic work_t f_cell_end(work_t w);
		work_t r;
		r = f_emit(w, EV_CELL, 8'h00, w.s.bold);
		r.s.rowc  = 1'b1;
		r.s.tpend = 1'b0;
		r.s.bold  = 1'b0;
		return r;
	endfunction

	function automatic work_t f_row_end(work_t w);
		work_t r;
		r = w;
		if (r.s.rowc) begin
			r = f_emit(r, EV_ROW, 8'h00, 1'b0);
			r.s.rowc = 1'b0;
		end
		r.s.table_on = 1'b0;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// word helpers
	function automatic logic f_letter(logic [7:0] c);
		return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
	endfunction

	function automatic logic f_digit(logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic work_t f_start_word(work_t w);
		work_t r;
		r = w;
		r.s.wmatch = 8'hFF;
		r.s.wlen   = 3'd0;
		r.s.pseen  = 1'b0;
		r.s.pnz    = 1'b0;
		return r;
	endfunction

	function automatic work_t f_word_letter(work_t w, logic [7:0] c);
		work_t r;
		r = w;
		for (int k = 0; k < 8; k++) begin
			if (r.s.wmatch[k] &&
			    !(r.s.wlen < KW_LEN[k] && KW_TEXT[k][r.s.wlen] == c)) begin
				r.s.wmatch[k] = 1'b0;
			end
		end
		if (r.s.wlen != 3'd7) r.s.wlen = r.s.wlen + 3'd1;
		return r;
	endfunction

	function automatic work_t f_digit_in(work_t w, logic [7:0] c);
		work_t r;
		r = w;
		r.s.pseen = 1'b1;
		if (c != CH_ZERO) r.s.pnz = 1'b1;
		return r;
	endfunction

	// act on a finished control word
	function automatic work_t f_dispatch(work_t w);
		work_t      r;
		logic       found;
		logic [2:0] hit;
		r     = w;
		found = 1'b0;
		hit   = KW_PAR;
		for (int k = 0; k < 8; k++) begin
			if (!found && r.s.wmatch[k] && KW_LEN[k] == r.s.wlen) begin
				found = 1'b1;
				hit   = 3'(k);
			end
		end
		if (r.s.skip == '0 && found) begin
			case (hit)
				KW_PAR, KW_PARD: begin
					if (r.s.table_on) r = f_cell_end(r);
					else r = f_para_end(r);
				end
				KW_B:     r.s.bold = !r.s.pseen || r.s.pnz;
				KW_TROWD: r.s.table_on = 1'b1;
				KW_CELL:  if (r.s.table_on) r = f_cell_end(r);
				KW_ROW:   if (r.s.table_on) r = f_row_end(r);
				KW_LINE, KW_TAB: r = f_append(r, CH_TAB);
				default: ;
			endcase
		end
		return r;
	endfunction

	// ordinary byte in text mode
	function automatic work_t f_plain(work_t w, logic [7:0] c);
		work_t      r;
		logic [1:0] old;
		r   = w;
		old = r.s.besc;
		if (c == CH_LBRACE) begin
			r.s.besc = BE_BRACE;
		end else begin
			r.s.besc = BE_NONE;
			if (c == CH_RBRACE) begin
				if (r.s.skip != '0) r.s.skip = r.s.skip - SKW'(1);
				else if (r.s.table_on) r = f_row_end(r);
				else r = f_para_end(r);
			end else if (c == CH_BSLASH) begin
				r.s.mode = M_ESC;
				r        = f_start_word(r);
				r.s.besc = (old == BE_BRACE) ? BE_SLASH : BE_NONE;
			end else if (r.s.skip == '0 && c != CH_CR && c != CH_LF) begin
				r = f_append(r, c);
			end
		end
		return r;
	endfunction

	// one data byte, from the opening brace on
	function automatic work_t f_data(work_t w, logic [7:0] c);
		work_t r;
		logic  was2;
		r = w;
		case (r.s.mode)
			M_ESC: begin
				was2     = (r.s.besc == BE_SLASH);
				r.s.besc = BE_NONE;
				if (was2 && c == CH_STAR && r.s.skip < SKW'(MAX_SKIP_DEPTH))
					r.s.skip = r.s.skip + SKW'(1);
				if (c inside {CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_TILDE, CH_MINUS,
				              CH_UNDER}) begin
					r.s.mode = M_TEXT;
					if (r.s.skip == '0) r = f_append(r, c);
				end else if (f_letter(c)) begin
					r.s.mode = M_WORD;
					r        = f_word_letter(r, c);
				end else if (f_digit(c)) begin
					r.s.mode = M_NUM;
					r        = f_digit_in(r, c);
				end else if (c == CH_SPACE) begin
					r.s.mode = M_TEXT;
					r        = f_dispatch(r);
				end else begin
					r.s.mode = M_TEXT;
					r        = f_plain(f_dispatch(r), c);
				end
			end
			M_WORD: begin
				if (f_letter(c)) begin
					r = f_word_letter(r, c);
				end else if (c == CH_MINUS) begin
					r.s.mode  = M_MINUS;
					r.s.pseen = 1'b1;
				end else if (f_digit(c)) begin
					r.s.mode = M_NUM;
					r        = f_digit_in(r, c);
				end else if (c == CH_SPACE) begin
					r.s.mode = M_TEXT;
					r        = f_dispatch(r);
				end else begin
					r.s.mode = M_TEXT;
					r        = f_plain(f_dispatch(r), c);
				end
			end
			M_MINUS: begin
				if (f_digit(c)) begin
					r.s.mode = M_NUM;
					r        = f_digit_in(r, c);
				end else begin
					r.s.mode = M_TEXT;
					r        = f_dispatch(r);
					if (r.s.skip == '0) r = f_append(r, CH_MINUS);
					r = f_plain(r, c);
				end
			end
			M_NUM: begin
				if (f_digit(c)) begin
					r = f_digit_in(r, c);
				end else begin
					r.s.mode = M_TEXT;
					r        = f_plain(f_dispatch(r), c);
				end
			end
			default: begin
				r.s.mode = M_TEXT;
				r        = f_plain(r, c);
			end
		endcase
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// parse the offered request against the current state
	always_comb begin
		w_nxt.s  = st_q;
		w_nxt.ev = '0;
		w_nxt.n  = 2'd0;
		if (s_tuser == KIND_DATA) begin
			if (st_q.started || s_tdata == CH_LBRACE) begin
				w_nxt.s.started = 1'b1;
				w_nxt           = f_data(w_nxt, s_tdata);
			end
		end else begin
			if (st_q.started) begin
				if (st_q.mode == M_WORD || st_q.mode == M_NUM) begin
					w_nxt = f_dispatch(w_nxt);
				end else if (st_q.mode == M_MINUS) begin
					w_nxt = f_dispatch(w_nxt);
					if (w_nxt.s.skip == '0) w_nxt = f_append(w_nxt, CH_MINUS);
				end
				if (w_nxt.s.table_on) w_nxt = f_row_end(w_nxt);
				else w_nxt = f_para_end(w_nxt);
			end
			w_nxt.s = ST_RESET;
		end
	end

	// accept while the buffer is empty or its last event leaves this cycle
	assign s_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;

	// hold parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
		end else if (s_acc) begin
			st_q <= w_nxt.s;
		end
	end

	// load or drain the result buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (s_acc) begin
			cnt_q <= w_nxt.n;
		end else if (m_acc) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			buf_q[0] <= w_nxt.ev[0];
			buf_q[1] <= w_nxt.ev[1];
			buf_q[2] <= w_nxt.ev[2];
		end else if (m_acc) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
		end
	end

	// present the head event
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {7'b0, buf_q[0].bold, buf_q[0].text};
	assign m_tuser  = buf_q[0].kind;
	assign m_tlast  = (cnt_q == 2'd1);

endmodule

`default_nettype wire

>>> verif/tb_rtf_token_event_parser.sv
// Self-checking testbench for the RTF token event parser: streams RTF bytes and end markers
// in, predicts every event in an in-bench parser model and checks each event that comes out.
// Depends on rtfp_pkg and rtf_token_event_parser.
module tb_rtf_token_event_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import rtfp_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_ITEMS   = 350;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 16;

	// one expected output event
	typedef struct {
		logic [1:0] kind;
		logic [7:0] text;
		logic       bold;
		logic       last;
	} event_rec_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;
	logic        s_tuser  = KIND_DATA;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	// parser model state
	logic        p_started;
	logic [2:0]  p_mode;
	logic [1:0]  p_besc;
	int unsigned p_skip;
	logic [7:0]  p_wmatch;
	logic [2:0]  p_wlen;
	logic        p_pseen;
	logic        p_pnz;
	logic        p_bold;
	logic        p_table;
	logic        p_tpend;
	logic        p_rowc;

	event_rec_t  step_events [3];
	int          step_count;
	event_rec_t  event_q [$];

	int          parsed_count = 0;
	int          err_count    = 0;
	int          idle_cycles  = 0;
	logic        tx_steady    = 1'b0;
	logic        rx_steady    = 1'b0;
	logic        hold_rx      = 1'b0;

	rtf_token_event_parser u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] byte_value
		.s_tuser  (s_tuser),   // [0] kind
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [7:0] text_byte, [8] bold_flag, [15:9] zero
		.m_tuser  (m_tuser),   // [1:0] event_kind
		.m_tlast  (m_tlast)    // last_of_run
	);

	always #HALF_PERIOD clk = ~clk;

	// ---------------------------------------------------------------- parser model

	function automatic void reset_model();
		p_started = 1'b0;
		p_mode    = M_TEXT;
		p_besc    = BE_NONE;
		p_skip    = 0;
		p_wmatch  = 8'h00;
		p_wlen    = 3'd0;
		p_pseen   = 1'b0;
		p_pnz     = 1'b0;
		p_bold    = 1'b0;
		p_table   = 1'b0;
		p_tpend   = 1'b0;
		p_rowc    = 1'b0;
	endfunction

	// record an event; a step carries at most three
	function automatic void emit_event(logic [1:0] k, logic [7:0] t, logic b);
		if (step_count < 3) begin
			step_events[step_count] = '{kind: k, text: t, bold: b, last: 1'b0};
			step_count++;
		end
	endfunction

	function automatic void add_text(logic [7:0] c);
		emit_event(EV_TEXT, c, 1'b0);
		p_tpend = 1'b1;
	endfunction

	// empty paragraphs produce nothing and keep bold
	function automatic void close_para();
		if (!p_tpend)
			return;
		emit_event(EV_PAR, 8'h00, p_bold);
		p_tpend = 1'b0;
		p_bold  = 1'b0;
	endfunction

	function automatic void close_cell();
		emit_event(EV_CELL, 8'h00, p_bold);
		p_rowc  = 1'b1;
		p_tpend = 1'b0;
		p_bold  = 1'b0;
	endfunction

	// a row end is reported only when the row holds cells
	function automatic void close_row();
		if (p_rowc) begin
			emit_event(EV_ROW, 8'h00, 1'b0);
			p_rowc = 1'b0;
		end
		p_table = 1'b0;
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	// narrow the keyword candidates by one more letter
	function automatic void take_letter(logic [7:0] c);
		for (int k = 0; k < 8; k++)
			if (p_wmatch[k] && !(p_wlen < KW_LEN[k] && KW_TEXT[k][p_wlen] == c))
				p_wmatch[k] = 1'b0;
		if (p_wlen < 3'd7)
			p_wlen++;
	endfunction

	function automatic void take_digit(logic [7:0] c);
		p_pseen = 1'b1;
		if (c != CH_ZERO)
			p_pnz = 1'b1;
	endfunction

	// act on a finished control word; words inside skipped groups do nothing
	function automatic void run_word();
		logic       found;
		logic [2:0] hit;
		found = 1'b0;
		hit   = KW_PAR;
		if (p_skip != 0)
			return;
		for (int k = 0; k < 8; k++)
			if (!found && p_wmatch[k] && KW_LEN[k] == p_wlen) begin
				found = 1'b1;
				hit   = k[2:0];
			end
		if (!found)
			return;
		case (hit)
			KW_PAR, KW_PARD: begin
				if (p_table)
					close_cell();
				else
					close_para();
			end
			KW_B:     p_bold = !p_pseen || p_pnz;
			KW_TROWD: p_table = 1'b1;
			KW_CELL: begin
				if (p_table)
					close_cell();
			end
			KW_ROW: begin
				if (p_table)
					close_row();
			end
			default:  add_text(CH_TAB);
		endcase
	endfunction

	// handle a byte in text mode
	function automatic void lex_plain(logic [7:0] c);
		logic [1:0] old;
		old = p_besc;
		if (c == CH_LBRACE) begin
			p_besc = BE_BRACE;
			return;
		end
		p_besc = BE_NONE;
		if (c == CH_RBRACE) begin
			if (p_skip > 0)
				p_skip--;
			else if (p_table)
				close_row();
			else
				close_para();
			return;
		end
		if (c == CH_BSLASH) begin
			p_mode   = M_ESC;
			p_wmatch = 8'hFF;
			p_wlen   = 3'd0;
			p_pseen  = 1'b0;
			p_pnz    = 1'b0;
			p_besc   = (old == BE_BRACE) ? BE_SLASH : BE_NONE;
			return;
		end
		if (p_skip == 0 && c != CH_CR && c != CH_LF)
			add_text(c);
	endfunction

	// predict the events of one accepted request and queue them
	function automatic void parse_request(logic k, logic [7:0] c);
		logic       was_slash;
		event_rec_t rec;
		step_count = 0;
		if (k == KIND_DATA && !p_started && c != CH_LBRACE)
			return;
		parsed_count++;
		if (k == KIND_DATA) begin
			p_started = 1'b1;
			case (p_mode)
				M_ESC: begin
					was_slash = (p_besc == BE_SLASH);
					p_besc    = BE_NONE;
					if (was_slash && c == CH_STAR && p_skip < MAX_SKIP_DEPTH)
						p_skip++;
					if (c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE ||
							c == CH_TILDE || c == CH_MINUS || c == CH_UNDER) begin
						p_mode = M_TEXT;
						if (p_skip == 0)
							add_text(c);
					end else if (is_alpha(c)) begin
						p_mode = M_WORD;
						take_letter(c);
					end else if (is_num(c)) begin
						p_mode = M_NUM;
						take_digit(c);
					end else if (c == CH_SPACE) begin
						p_mode = M_TEXT;
						run_word();
					end else begin
						p_mode = M_TEXT;
						run_word();
						lex_plain(c);
					end
				end
				M_WORD: begin
					if (is_alpha(c)) begin
						take_letter(c);
					end else if (c == CH_MINUS) begin
						p_mode  = M_MINUS;
						p_pseen = 1'b1;
					end else if (is_num(c)) begin
						p_mode = M_NUM;
						take_digit(c);
					end else if (c == CH_SPACE) begin
						p_mode = M_TEXT;
						run_word();
					end else begin
						p_mode = M_TEXT;
						run_word();
						lex_plain(c);
					end
				end
				M_MINUS: begin
					if (is_num(c)) begin
						p_mode = M_NUM;
						take_digit(c);
					end else begin
						p_mode = M_TEXT;
						run_word();
						if (p_skip == 0)
							add_text(CH_MINUS);
						lex_plain(c);
					end
				end
				M_NUM: begin
					if (is_num(c)) begin
						take_digit(c);
					end else begin
						p_mode = M_TEXT;
						run_word();
						lex_plain(c);
					end
				end
				default: begin
					p_mode = M_TEXT;
					lex_plain(c);
				end
			endcase
		end else begin
			// finish any word, flush the row or paragraph, start over
			if (p_started) begin
				if (p_mode == M_WORD || p_mode == M_NUM) begin
					run_word();
				end else if (p_mode == M_MINUS) begin
					run_word();
					if (p_skip == 0)
						add_text(CH_MINUS);
				end
				if (p_table)
					close_row();
				else
					close_para();
			end
			reset_model();
		end
		for (int i = 0; i < step_count; i++) begin
			rec      = step_events[i];
			rec.last = (i == step_count - 1);
			event_q.push_back(rec);
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("ERROR: %s got %0d want %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// compare each accepted event with the oldest prediction
	always @(posedge clk) begin : check_events
		event_rec_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) begin
			if (event_q.size() == 0) begin
				report_mismatch("event with none expected, event_kind", int'(m_tuser), -1);
			end else begin
				want = event_q.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("event_kind", int'(m_tuser), int'(want.kind));
				if (m_tdata[7:0] !== want.text)
					report_mismatch("text_byte", int'(m_tdata[7:0]), int'(want.text));
				if (m_tdata[8] !== want.bold)
					report_mismatch("bold_flag", int'(m_tdata[8]), int'(want.bold));
				if (m_tdata[15:9] !== 7'd0)
					report_mismatch("tdata padding", int'(m_tdata[15:9]), 0);
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", int'(m_tlast), int'(want.last));
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- pacing

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(3, 1);
		else
			return $urandom_range(40, 8);
	endfunction

	// drive the event receiver: random stalls, or one long hold on request
	always begin
		@(posedge clk);
		if (hold_rx) begin
			m_tready <= 1'b0;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			hold_rx = 1'b0;
			m_tready <= 1'b1;
		end else if (rx_steady || $urandom_range(99) < 70) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= 1'b0;
			repeat (pick_gap() + 1) @(posedge clk);
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------- stimulus

	// offer one request and hold it until accepted
	task automatic send_req(input logic k, input logic [7:0] b);
		int gap;
		gap = tx_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		parse_request(k, b);
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++)
			send_req(KIND_DATA, s[i]);
	endtask

	// drop valid and wait until every predicted event has arrived
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (event_q.size() != 0);
	endtask

	task automatic send_digits();
		int n;
		n = $urandom_range(3, 1);
		repeat (n)
			send_req(KIND_DATA, $urandom_range(1) ? CH_ZERO : 8'("0" + $urandom_range(9)));
	endtask

	// what follows a word name: space, parameter, lone minus or nothing
	task automatic send_word_tail();
		int r;
		r = $urandom_range(99);
		if (r < 35) begin
			send_req(KIND_DATA, CH_SPACE);
		end else if (r < 55) begin
			send_digits();
		end else if (r < 65) begin
			send_req(KIND_DATA, CH_MINUS);
			send_digits();
		end else if (r < 75) begin
			send_req(KIND_DATA, CH_MINUS);
		end
	endtask

	// a known keyword, now and then cut short or with an extra letter
	task automatic send_keyword(input logic [2:0] k);
		int r;
		r = $urandom_range(99);
		send_req(KIND_DATA, CH_BSLASH);
		for (int j = 0; j < KW_LEN[k]; j++)
			if (!(r < 8 && j == KW_LEN[k] - 1))
				send_req(KIND_DATA, KW_TEXT[k][j]);
		if (r >= 90)
			send_req(KIND_DATA, 8'("a" + $urandom_range(25)));
		send_word_tail();
	endtask

	// an unknown word of mixed case, up to ten letters
	task automatic send_name();
		int n;
		n = $urandom_range(10, 1);
		send_req(KIND_DATA, CH_BSLASH);
		repeat (n)
			send_req(KIND_DATA, 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25)));
		send_word_tail();
	endtask

	task automatic send_text(input int n);
		logic [7:0] c;
		repeat (n) begin
			c = 8'($urandom_range(8'h7E, 8'h20));
			if (c == CH_BSLASH || c == CH_LBRACE || c == CH_RBRACE)
				c = "x";
			send_req(KIND_DATA, c);
		end
	endtask

	// one mostly well-formed piece of RTF with random content
	task automatic send_fragment();
		int         r;
		logic [7:0] esc_set [8];
		esc_set = '{CH_BSLASH, CH_LBRACE, CH_RBRACE, CH_TILDE, CH_MINUS, CH_UNDER, "'", CH_STAR};
		r = $urandom_range(99);
		if (r < 22) begin
			send_text($urandom_range(4, 1));
		end else if (r < 44) begin
			send_keyword(3'($urandom_range(7)));
		end else if (r < 50) begin
			send_name();
		end else if (r < 57) begin
			send_req(KIND_DATA, CH_BSLASH);
			send_req(KIND_DATA, $urandom_range(4) != 0 ? esc_set[$urandom_range(7)]
				: 8'($urandom_range(255)));
		end else if (r < 65) begin
			send_req(KIND_DATA, $urandom_range(1) ? CH_LBRACE : CH_RBRACE);
		end else if (r < 71) begin
			// destination group, sometimes with a brace-backslash that is not one
			send_req(KIND_DATA, CH_LBRACE);
			send_req(KIND_DATA, CH_BSLASH);
			send_req(KIND_DATA, $urandom_range(4) != 0 ? CH_STAR
				: 8'("a" + $urandom_range(25)));
			send_name();
			send_text($urandom_range(2));
			if ($urandom_range(1))
				send_req(KIND_DATA, CH_RBRACE);
		end else if (r < 75) begin
			send_req(KIND_DATA, $urandom_range(1) ? CH_CR : CH_LF);
		end else if (r < 82) begin
			// a table row with up to three cells
			send_keyword(KW_TROWD);
			repeat ($urandom_range(3)) begin
				send_text($urandom_range(2));
				if ($urandom_range(3) == 0)
					send_keyword(KW_B);
				send_keyword($urandom_range(4) == 0 ? KW_PAR : KW_CELL);
			end
			if ($urandom_range(3) != 0)
				send_keyword(KW_ROW);
		end else if (r < 90) begin
			send_req(KIND_DATA, 8'($urandom_range(255)));
		end else if (r < 94) begin
			// end of document, then a fresh one
			send_req(KIND_END, 8'($urandom_range(255)));
			if ($urandom_range(9) == 0)
				send_req(KIND_DATA, 8'($urandom_range(255)));
			send_req(KIND_DATA, CH_LBRACE);
		end else begin
			send_keyword(KW_B);
		end
	endtask

	// ---------------------------------------------------------------- tests

	// preamble bytes, zero and all-ones bytes, CR and LF
	task automatic test_extremes();
		send_req(KIND_DATA, 8'h00);
		send_req(KIND_DATA, 8'hFF);
		send_req(KIND_DATA, CH_LBRACE);
		send_req(KIND_DATA, 8'h00);
		send_req(KIND_DATA, 8'hFF);
		send_req(KIND_DATA, CH_CR);
		send_req(KIND_DATA, CH_LF);
		send_req(KIND_END, 8'hFF);
	endtask

	// bold, paragraph ends, word endings, lone minus, tab and line
	task automatic test_words();
		send_str("{\\b x\\par\\par \\b0-\\b-y\\tab\\line}");
		send_req(KIND_END, 8'h00);
	endtask

	// cells, rows with and without cells, row end by a brace
	task automatic test_table();
		send_str("{\\trowd\\b a\\cell\\row\\row b\\trowd\\par\\cell}\\trowd\\b1");
		send_req(KIND_END, 8'h00);
	endtask

	// skipped groups ended early by a nested brace, escape symbols
	task automatic test_skip_groups();
		send_str("{a{\\*\\x {y}z}\\{\\}\\~\\_\\\\\\-{\\b}w\\pard-");
		send_req(KIND_END, 8'h55);
	endtask

	// push the skip counter past its ceiling and count it back down
	task automatic test_skip_saturation();
		send_req(KIND_DATA, CH_LBRACE);
		repeat (MAX_SKIP_DEPTH + 1)
			send_str("{\\*");
		send_req(KIND_DATA, "q");
		repeat (MAX_SKIP_DEPTH)
			send_req(KIND_DATA, CH_RBRACE);
		send_req(KIND_DATA, "r");
		send_req(KIND_END, 8'h00);
	endtask

	// hold the receiver off while text keeps coming, so the input stalls
	task automatic test_backpressure();
		tx_steady = 1'b1;
		hold_rx   = 1'b1;
		send_req(KIND_DATA, CH_LBRACE);
		send_text(30);
		send_req(KIND_END, 8'h00);
		tx_steady = 1'b0;
		wait_drained();
	endtask

	// random documents, with stretches of no idling on either side
	task automatic test_random();
		int target;
		target = parsed_count + RANDOM_ITEMS;
		send_req(KIND_DATA, CH_LBRACE);
		while (parsed_count < target) begin
			if ($urandom_range(29) == 0)
				tx_steady = ~tx_steady;
			if ($urandom_range(29) == 0)
				rx_steady = ~rx_steady;
			send_fragment();
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		send_req(KIND_END, 8'($urandom_range(255)));
	endtask

	initial begin
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_words();
		test_table();
		test_skip_groups();
		wait_drained();
		test_skip_saturation();
		wait_drained();
		test_backpressure();
		test_random();
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && event_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
